// ----- design/sbpm_pkg.sv -----
// Shared types and constants for the spectrum band peak meter.
`default_nettype none
package sbpm_pkg;

    localparam int MAG_W   = 24;
    localparam int MS_W    = 16;
    localparam int EDGE_W  = 10;
    localparam int BIDX_W  = 3;
    localparam int LVL_W   = 16;
    localparam int SUM_W   = 34;
    localparam int DECAY_W = 16;
    localparam int CFGI_W  = 2;
    localparam int CFGD_W  = 24;
    localparam int DIVN_W  = 40;
    localparam int DIVD_W  = 24;

    localparam logic [CFGI_W-1:0] CFG_DECAY_RATE = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_MAX_LEVEL  = 2'd1;

    typedef enum logic [1:0] {
        OP_EDGE,
        OP_BIN,
        OP_BIN_LAST
    } t_op;

    typedef struct packed {
        t_op                op;
        logic [MAG_W-1:0]   magnitude;
        logic [MS_W-1:0]    frame_time_ms;
        logic [BIDX_W-1:0]  edge_index;
        logic [EDGE_W-1:0]  edge_value;
    } t_qitem;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEEK,
        S_PGO,
        S_PDIV,
        S_BAND,
        S_AVG,
        S_DECAY,
        S_LVLGO,
        S_LVL,
        S_OUT
    } t_state;

endpackage
`default_nettype wire

// ----- design/sbpm_in_if.sv -----
// Input channel: bins and band edge writes.
`default_nettype none
interface sbpm_in_if;
    import sbpm_pkg::*;
    logic                valid;
    logic                ready;
    logic                action;
    logic [MAG_W-1:0]    magnitude;
    logic                last_bin;
    logic [MS_W-1:0]     frame_time_ms;
    logic [BIDX_W-1:0]   edge_index;
    logic [EDGE_W-1:0]   edge_value;
    modport source (output valid, action, magnitude, last_bin, frame_time_ms,
                    edge_index, edge_value, input ready);
    modport sink (input valid, action, magnitude, last_bin, frame_time_ms,
                  edge_index, edge_value, output ready);
endinterface
`default_nettype wire

// ----- design/sbpm_out_if.sv -----
// Output channel: one level per band.
`default_nettype none
interface sbpm_out_if;
    import sbpm_pkg::*;
    logic                valid;
    logic                ready;
    logic [BIDX_W-1:0]   band_index;
    logic [LVL_W-1:0]    level;
    logic                last_band;
    modport source (output valid, band_index, level, last_band, input ready);
    modport sink (input valid, band_index, level, last_band, output ready);
endinterface
`default_nettype wire

// ----- design/sbpm_front.sv -----
// Front end: accept items, classify them and queue them for the back end.
`default_nettype none
module sbpm_front
    import sbpm_pkg::*;
#(
    parameter int BANDS = 8
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    sbpm_in_if.sink      i_in,
    output t_qitem       o_q,
    output logic         o_q_valid,
    input  wire logic    i_q_pop
);

    t_qitem     r_buf [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       acc;
    logic       push;
    logic       drop_edge;
    t_qitem     item;

    assign i_in.ready = (r_cnt != 2'd2);
    assign acc        = i_in.valid && i_in.ready;
    // drop edge writes to a band that does not exist
    assign drop_edge  = i_in.action && (32'(i_in.edge_index) >= BANDS);
    assign push       = acc && !drop_edge;

    always_comb begin
        item.op            = i_in.action ? OP_EDGE : (i_in.last_bin ? OP_BIN_LAST : OP_BIN);
        item.magnitude     = i_in.magnitude;
        item.frame_time_ms = i_in.frame_time_ms;
        item.edge_index    = i_in.edge_index;
        item.edge_value    = i_in.edge_value;
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_q_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_q_pop);
        end
    end

    assign o_q       = r_buf[r_rd];
    assign o_q_valid = (r_cnt != 2'd0);

endmodule
`default_nettype wire

// ----- design/sbpm_div.sv -----
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module sbpm_div
    import sbpm_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DIVN_W-1:0] i_dividend,
    input  wire logic [DIVD_W-1:0] i_divisor,
    output logic                   o_busy,
    output logic                   o_done,
    output logic [DIVN_W-1:0]      o_quot
);

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic [DIVN_W-1:0] r_q;
    logic [DIVD_W-1:0] r_rem;
    logic [DIVD_W-1:0] r_d;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_done;
    logic [DIVD_W:0]   trial;
    logic              ge;

    assign trial = {r_rem, r_q[DIVN_W-1]};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? DIVD_W'(trial - {1'b0, r_d}) : trial[DIVD_W-1:0];
            r_q   <= {r_q[DIVN_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) r_cnt <= CNT_W'(DIVN_W);
            else if (r_cnt != '0) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule
`default_nettype wire

// ----- design/sbpm_back.sv -----
// Back end: band sums, frame-end averaging, peak hold, decay and level.
`default_nettype none
module sbpm_back
    import sbpm_pkg::*;
#(
    parameter int BANDS    = 8,
    parameter int MAX_BINS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  t_qitem                 i_q,
    input  wire logic              i_q_valid,
    output logic                   o_q_pop,
    input  wire logic              i_cfg_we,
    input  wire logic [CFGI_W-1:0] i_cfg_idx,
    input  wire logic [CFGD_W-1:0] i_cfg_data,
    sbpm_out_if.source             o_out
);

    localparam int PW = $clog2(BANDS + 1);
    localparam int IW = (BANDS > 1) ? $clog2(BANDS) : 1;
    localparam int CW = $clog2(MAX_BINS + 1);
    localparam int XW = (CW > EDGE_W) ? CW : EDGE_W;
    localparam logic [PW-1:0] PTR_END  = PW'(BANDS);
    localparam logic [PW-1:0] PTR_LAST = PW'(BANDS - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_BINS);
    localparam logic [SUM_W-1:0] SUM_MAX = '1;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;
    // decay*ms*256/1000 reaches 65536 from decay*ms = 256000 upwards
    localparam logic [31:0] DMS_SAT   = 32'd256000;
    // ceil(2^30 / 125): exact floor(n / 125) for n below 2^23
    localparam logic [23:0] RECIP_125 = 24'd8589935;

    t_state r_state, n_state;

    logic [EDGE_W-1:0]  r_edges [BANDS];
    logic [SUM_W-1:0]   r_sums  [BANDS];
    logic [MAG_W-1:0]   r_peaks [BANDS];
    logic [DECAY_W-1:0] r_decay;
    logic [MAG_W-1:0]   r_maxl;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_b;
    logic [PW-1:0]      r_ptr;
    logic [MAG_W-1:0]   r_mag;
    logic               r_last;
    logic [MS_W-1:0]    r_ms;
    logic [31:0]        r_dms;
    logic [16:0]        r_f;
    logic [EDGE_W-1:0]  r_start;
    logic [MAG_W-1:0]   r_avg;
    logic [MAG_W-1:0]   r_peak;
    logic [LVL_W-1:0]   r_lvl;
    logic               r_ov;
    logic [BIDX_W-1:0]  r_obi;
    logic [LVL_W-1:0]   r_olvl;
    logic               r_olast;

    logic [IW-1:0]      idx;
    logic               ptr_in;
    logic [EDGE_W-1:0]  e_cur;
    logic               seek_step;
    logic [EDGE_W-1:0]  span;
    logic               div_start;
    logic [DIVN_W-1:0]  div_n;
    logic [DIVD_W-1:0]  div_d;
    logic               div_busy;
    logic               div_done;
    logic [DIVN_W-1:0]  div_q;
    logic               out_load;
    logic               out_free;
    logic [SUM_W:0]     sum_add;
    logic [MAG_W-1:0]   peak_max;
    logic [40:0]        peak_mul;
    logic [31:0]        dms;
    logic [22:0]        p_num;
    logic [46:0]        p_mul;
    logic [16:0]        p_val;

    assign idx      = r_ptr[IW-1:0];
    assign ptr_in   = r_ptr < PTR_END;
    assign e_cur    = r_edges[idx];
    assign seek_step = ptr_in && (XW'(e_cur) <= XW'(r_b));
    assign span     = (e_cur > r_start) ? EDGE_W'(e_cur - r_start) : '0;
    assign out_free = !r_ov || o_out.ready;
    assign sum_add  = {1'b0, r_sums[idx]} + (SUM_W + 1)'(r_mag);
    assign peak_max = (r_avg > r_peaks[idx]) ? r_avg : r_peaks[idx];
    assign peak_mul = 41'(peak_max) * 41'(r_f);
    assign dms      = 32'(r_decay) * 32'(r_ms);
    // decay*ms*256/1000 = decay*ms*32/125, only needed below the saturation point
    assign p_num    = {r_dms[17:0], 5'd0};
    assign p_mul    = 47'(p_num) * 47'(RECIP_125);
    assign p_val    = p_mul[46:30];

    sbpm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_n),
        .i_divisor  (div_d),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state   = r_state;
        o_q_pop   = 1'b0;
        div_start = 1'b0;
        div_n     = '0;
        div_d     = '0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    if (i_q.op != OP_EDGE) begin
                        if (r_cnt < CNT_MAX && r_cnt != '0) n_state = S_SEEK;
                        else if (i_q.op == OP_BIN_LAST)     n_state = S_PGO;
                    end
                end
            end
            S_SEEK: begin
                if (!seek_step) n_state = r_last ? S_PGO : S_IDLE;
            end
            S_PGO: begin
                n_state = S_PDIV;
            end
            S_PDIV: begin
                n_state = S_BAND;
            end
            S_BAND: begin
                if (span != '0) begin
                    div_start = 1'b1;
                    div_n     = DIVN_W'(r_sums[idx]);
                    div_d     = DIVD_W'(span);
                    n_state   = S_AVG;
                end else begin
                    n_state = S_DECAY;
                end
            end
            S_AVG: begin
                if (div_done) n_state = S_DECAY;
            end
            S_DECAY: n_state = S_LVLGO;
            S_LVLGO: begin
                div_start = 1'b1;
                div_n     = DIVN_W'({r_peak, 14'd0});
                div_d     = (r_maxl == '0) ? DIVD_W'(1) : r_maxl;
                n_state   = S_LVL;
            end
            S_LVL: begin
                if (div_done) n_state = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    out_load = 1'b1;
                    n_state  = (r_ptr == PTR_LAST) ? S_IDLE : S_BAND;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DECAY_RATE: r_decay <= i_cfg_data[DECAY_W-1:0];
                CFG_MAX_LEVEL:  r_maxl  <= i_cfg_data;
                default: ;
            endcase
        end
        if (!i_rst_n) begin
            r_decay <= DECAY_W'(256);
            r_maxl  <= MAG_W'(4096);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_q_valid && i_q.op == OP_EDGE) begin
            r_edges[i_q.edge_index[IW-1:0]] <= i_q.edge_value;
        end
    end

    // per-item and per-band payload
    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mag  <= i_q.magnitude;
            r_last <= (i_q.op == OP_BIN_LAST);
            r_ms   <= i_q.frame_time_ms;
            r_b    <= r_cnt;
        end
        if (r_state == S_PGO) begin
            r_dms <= dms;
        end
        if (r_state == S_PDIV) begin
            r_f <= (r_dms >= DMS_SAT) ? 17'd0 : 17'h10000 - p_val;
        end
        if (r_state == S_BAND) begin
            r_avg <= '0;
            if (e_cur > r_start) r_start <= e_cur;
        end else if (r_state == S_PDIV) begin
            r_start <= EDGE_W'(1);
        end
        if (r_state == S_AVG && div_done) begin
            r_avg <= (div_q > DIVN_W'(MAG_MAX)) ? MAG_MAX : div_q[MAG_W-1:0];
        end
        if (r_state == S_DECAY) begin
            r_peak <= peak_mul[MAG_W+15:16];
        end
        if (r_state == S_LVL && div_done) begin
            r_lvl <= (div_q > DIVN_W'(16'hFFFF)) ? 16'hFFFF : div_q[LVL_W-1:0];
        end
        if (out_load) begin
            r_obi   <= BIDX_W'(r_ptr);
            r_olvl  <= r_lvl;
            r_olast <= (r_ptr == PTR_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ptr <= '0;
            r_ov  <= 1'b0;
            for (int i = 0; i < BANDS; i++) begin
                r_sums[i]  <= '0;
                r_peaks[i] <= '0;
            end
        end else begin
            if (o_q_pop && i_q.op != OP_EDGE && r_cnt < CNT_MAX) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (r_state == S_SEEK) begin
                if (seek_step) begin
                    r_ptr <= r_ptr + PW'(1);
                end else if (ptr_in) begin
                    r_sums[idx] <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                end
            end
            if (r_state == S_PDIV) r_ptr <= '0;
            if (r_state == S_DECAY) r_peaks[idx] <= peak_mul[MAG_W+15:16];
            if (out_load) begin
                r_sums[idx] <= '0;
                if (r_ptr == PTR_LAST) begin
                    r_ptr <= '0;
                    r_cnt <= '0;
                end else begin
                    r_ptr <= r_ptr + PW'(1);
                end
            end
            if (out_load)           r_ov <= 1'b1;
            else if (o_out.ready)   r_ov <= 1'b0;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.band_index = r_obi;
    assign o_out.level      = r_olvl;
    assign o_out.last_band  = r_olast;

    a_ptr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ptr <= PTR_END)
        else $error("band pointer beyond band count");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (r_state == S_OUT) && out_free)
        else $error("result loaded outside the output step");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == S_IDLE) && i_q_valid)
        else $error("queue popped while busy");

endmodule
`default_nettype wire

// ----- design/spectrum_band_peak_meter_top.sv -----
// Top level of the spectrum band peak meter.
// Flow: an edge write is stored straight from the queue; a bin walks the band pointer
// past each band edge it passes. A last bin then computes the decay factor and, per band,
// runs up to two 40-bit divisions in the shared divider and waits out output stalls. A
// two-entry queue takes items while the back end works.
// Reset: synchronous active low; sums, peaks, counters clear at once, edges stay unset.
`default_nettype none
module spectrum_band_peak_meter_top
    import sbpm_pkg::*;
#(
    parameter int BANDS    = 8,
    parameter int MAX_BINS = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    sbpm_in_if.sink                i_in,
    sbpm_out_if.source             o_out,
    input  wire logic              i_cfg_we,
    input  wire logic [CFGI_W-1:0] i_cfg_idx,
    input  wire logic [CFGD_W-1:0] i_cfg_data
);

    t_qitem q;
    logic   q_valid;
    logic   q_pop;

    sbpm_front #(.BANDS(BANDS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .o_q       (q),
        .o_q_valid (q_valid),
        .i_q_pop   (q_pop)
    );

    sbpm_back #(.BANDS(BANDS), .MAX_BINS(MAX_BINS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q        (q),
        .i_q_valid  (q_valid),
        .o_q_pop    (q_pop),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
